>>> rtl/pal_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_pkg: shared types and constants of the positional array list
// Operation and status codes, sequencer states, field widths and the
// result word that the sequencer hands to the output register.
// ----------------------------------------------------------------------------
package pal_pkg;

  // Default number of list entries.
  localparam int PAL_DEPTH = 64;

  // Fixed field widths of the request and response words.
  localparam int OPW   = 3;
  localparam int POSW  = 7;
  localparam int DATAW = 32;
  localparam int STATW = 3;
  localparam int CNTOW = 7;

  // Request operations.
  typedef enum logic [OPW-1:0] {
    OP_INSERT = 3'd0,
    OP_DELETE = 3'd1,
    OP_GET    = 3'd2,
    OP_LOCATE = 3'd3,
    OP_CLEAR  = 3'd4
  } pal_op_t;

  // Response status codes.
  typedef enum logic [STATW-1:0] {
    STAT_OK       = 3'd0,
    STAT_BADPOS   = 3'd1,
    STAT_FULL     = 3'd2,
    STAT_EMPTY    = 3'd3,
    STAT_NOTFOUND = 3'd4
  } pal_status_t;

  // Sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN,
    S_FINISH
  } pal_state_t;

  // One response word as produced by the sequencer.
  typedef struct packed {
    pal_status_t              status;
    logic signed [DATAW-1:0]  element;
    logic [POSW-1:0]          found_position;
    logic [CNTOW-1:0]         count;
    logic                     is_empty;
  } pal_result_t;

endpackage

>>> rtl/pal_req_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_req_if: request channel
// Carries one request word (opcode, position, value) under valid/ready.
// ----------------------------------------------------------------------------
interface pal_req_if;

  logic                              valid;
  logic                              ready;
  logic [pal_pkg::OPW-1:0]           opcode;
  logic [pal_pkg::POSW-1:0]          position;
  logic signed [pal_pkg::DATAW-1:0]  value;

  modport source (output valid, output opcode, output position, output value,
                  input ready);
  modport sink   (input valid, input opcode, input position, input value,
                  output ready);

endinterface

>>> rtl/pal_rsp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_rsp_if: response channel
// Carries one response word (status, element, position, count, empty flag).
// ----------------------------------------------------------------------------
interface pal_rsp_if;

  logic                              valid;
  logic                              ready;
  logic [pal_pkg::STATW-1:0]         status;
  logic signed [pal_pkg::DATAW-1:0]  element;
  logic [pal_pkg::POSW-1:0]          found_position;
  logic [pal_pkg::CNTOW-1:0]         count;
  logic                              is_empty;

  modport source (output valid, output status, output element,
                  output found_position, output count, output is_empty,
                  input ready);
  modport sink   (input valid, input status, input element,
                  input found_position, input count, input is_empty,
                  output ready);

endinterface

>>> rtl/positional_array_list_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit: bounded ordered list of 32-bit words
// Insert, delete, get, locate and clear by one-based position.
// ----------------------------------------------------------------------------
// Usage:
//   Requests arrive on req (opcode, position, value) and each produces one
//   response word on rsp (status, element, found_position, count, is_empty).
//   Words move when valid and ready are both high at a rising clock edge.
//   The block holds one request at a time; req.ready is high only while the
//   sequencer is idle.
//   Each request is checked, then walks storage entries, then its response
//   is loaded: insert walks count-position+1 entries, delete walks
//   count-position+1, get walks one, locate walks up to count and, when it
//   stops at a match before the end, reads one entry more. Errors, clear and
//   unused opcodes skip the walk; an insert at the end of the list or a
//   locate on an empty list enters it with no entry to read. The walk goes
//   through the single read port, one entry per cycle. The next request is
//   taken in the cycle after the response is loaded; the response sits in an
//   output register, so the next request is taken while an earlier response
//   still waits; if the receiver stalls, the sequencer holds its finished
//   result until the register frees. Synchronous reset empties the list
//   and drops any pending response; the element memory is not cleared.
// ----------------------------------------------------------------------------
module positional_array_list_unit #(
  parameter int DEPTH = pal_pkg::PAL_DEPTH
) (
  input  logic      clk,
  input  logic      rst,
  pal_req_if.sink   req,
  pal_rsp_if.source rsp
);
  import pal_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic              out_free;
  logic              out_load;
  pal_result_t       out_data;
  logic              mem_we;
  logic [AW-1:0]     mem_waddr;
  logic [DATAW-1:0]  mem_wdata;
  logic              mem_re;
  logic [AW-1:0]     mem_raddr;
  logic [DATAW-1:0]  mem_rdata;

  logic              rsp_valid;
  pal_result_t       rsp_data;

  // Sequencer.
  pal_ctrl #(
    .DEPTH (DEPTH),
    .AW    (AW),
    .CW    (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .out_free  (out_free),
    .out_load  (out_load),
    .out_data  (out_data),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  // Element storage.
  pal_mem #(
    .DEPTH (DEPTH),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Output register: free when empty or being taken this cycle.
  assign out_free = !rsp_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (out_load) begin
      rsp_valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      rsp_data <= out_data;
    end
  end

  // Response channel.
  assign rsp.valid          = rsp_valid;
  assign rsp.status         = rsp_data.status;
  assign rsp.element        = rsp_data.element;
  assign rsp.found_position = rsp_data.found_position;
  assign rsp.count          = rsp_data.count;
  assign rsp.is_empty       = rsp_data.is_empty;

endmodule

>>> rtl/pal_mem.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_mem: element storage
// Single write port and single read port with registered read data.
// ----------------------------------------------------------------------------
module pal_mem #(
  parameter int DEPTH = pal_pkg::PAL_DEPTH,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                        clk,
  input  logic                        we,
  input  logic [AW-1:0]               waddr,
  input  logic [pal_pkg::DATAW-1:0]   wdata,
  input  logic                        re,
  input  logic [AW-1:0]               raddr,
  output logic [pal_pkg::DATAW-1:0]   rdata
);
  import pal_pkg::*;

  logic [DATAW-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> rtl/pal_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pal_ctrl: list sequencer
// Checks each request, then walks the storage one entry per cycle through
// the shared read port to shift, read or search, and builds the response.
// ----------------------------------------------------------------------------
module pal_ctrl #(
  parameter int DEPTH = pal_pkg::PAL_DEPTH,
  parameter int AW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                        clk,
  input  logic                        rst,
  pal_req_if.sink                     req,
  input  logic                        out_free,
  output logic                        out_load,
  output pal_pkg::pal_result_t        out_data,
  output logic                        mem_we,
  output logic [AW-1:0]               mem_waddr,
  output logic [pal_pkg::DATAW-1:0]   mem_wdata,
  output logic                        mem_re,
  output logic [AW-1:0]               mem_raddr,
  input  logic [pal_pkg::DATAW-1:0]   mem_rdata
);
  import pal_pkg::*;

  // Width that holds both a position and a count with room for one more.
  localparam int XW = ((CW > POSW) ? CW : POSW) + 1;
  localparam logic [XW-1:0] DEPTH_X = XW'(DEPTH);

  pal_state_t        state, state_next;
  logic [OPW-1:0]    op, op_next;
  logic [POSW-1:0]   pos, pos_next;
  logic [DATAW-1:0]  val, val_next;
  logic [CW-1:0]     cnt, cnt_next;
  logic [AW-1:0]     ra, ra_next;
  logic [CW-1:0]     left, left_next;
  logic              pend, pend_next;
  logic [AW-1:0]     paddr, paddr_next;
  logic              hit, hit_next;
  pal_status_t       status, status_next;
  logic [DATAW-1:0]  elem, elem_next;
  logic [POSW-1:0]   found, found_next;

  logic [XW-1:0]     pos_x, cnt_x, span_x, cnt_m1_x, pos_m1_x, found_x, cnt_after_x;
  logic [CW-1:0]     cnt_after;

  // Widened operands for position checks and address setup.
  assign pos_x    = XW'(pos);
  assign cnt_x    = XW'(cnt);
  assign span_x   = cnt_x - pos_x + XW'(1);
  assign cnt_m1_x = cnt_x - XW'(1);
  assign pos_m1_x = pos_x - XW'(1);
  assign found_x  = XW'(paddr) + XW'(1);

  // Element count once the current request has taken effect.
  always_comb begin
    cnt_after = cnt;
    if (status == STAT_OK) begin
      case (op)
        OP_INSERT: cnt_after = cnt + CW'(1);
        OP_DELETE: cnt_after = cnt - CW'(1);
        OP_CLEAR:  cnt_after = '0;
        default:   cnt_after = cnt;
      endcase
    end
  end
  assign cnt_after_x = XW'(cnt_after);

  // Response word.
  always_comb begin
    out_data.status         = status;
    out_data.element        = elem;
    out_data.found_position = found;
    out_data.count          = cnt_after_x[CNTOW-1:0];
    out_data.is_empty       = (cnt_after == '0);
  end

  // State and working registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      cnt   <= '0;
      pend  <= 1'b0;
      left  <= '0;
    end else begin
      state <= state_next;
      cnt   <= cnt_next;
      pend  <= pend_next;
      left  <= left_next;
    end
  end

  always_ff @(posedge clk) begin
    op     <= op_next;
    pos    <= pos_next;
    val    <= val_next;
    ra     <= ra_next;
    paddr  <= paddr_next;
    hit    <= hit_next;
    status <= status_next;
    elem   <= elem_next;
    found  <= found_next;
  end

  // Next state, memory port control and response hand-off.
  always_comb begin
    state_next  = state;
    op_next     = op;
    pos_next    = pos;
    val_next    = val;
    cnt_next    = cnt;
    ra_next     = ra;
    left_next   = left;
    pend_next   = pend;
    paddr_next  = paddr;
    hit_next    = hit;
    status_next = status;
    elem_next   = elem;
    found_next  = found;
    mem_we      = 1'b0;
    mem_waddr   = paddr;
    mem_wdata   = mem_rdata;
    mem_re      = 1'b0;
    mem_raddr   = ra;
    out_load    = 1'b0;
    req.ready   = (state == S_IDLE);

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          op_next    = req.opcode;
          pos_next   = req.position;
          val_next   = req.value;
          state_next = S_CHECK;
        end
      end

      // Validate the request and set up the walk over the storage.
      S_CHECK: begin
        status_next = STAT_OK;
        elem_next   = '0;
        found_next  = '0;
        hit_next    = 1'b0;
        pend_next   = 1'b0;
        left_next   = '0;
        state_next  = S_FINISH;
        unique case (op) inside
          OP_INSERT: begin
            if (pos_x == '0 || pos_x > cnt_x + XW'(1)) begin
              status_next = STAT_BADPOS;
            end else if (cnt_x >= DEPTH_X) begin
              status_next = STAT_FULL;
            end else begin
              left_next  = span_x[CW-1:0];
              ra_next    = cnt_m1_x[AW-1:0];
              state_next = S_SCAN;
            end
          end
          OP_DELETE, OP_GET: begin
            if (cnt_x == '0) begin
              status_next = STAT_EMPTY;
            end else if (pos_x == '0 || pos_x > cnt_x) begin
              status_next = STAT_BADPOS;
            end else begin
              left_next  = (op == OP_GET) ? CW'(1) : span_x[CW-1:0];
              ra_next    = pos_m1_x[AW-1:0];
              state_next = S_SCAN;
            end
          end
          OP_LOCATE: begin
            status_next = STAT_NOTFOUND;
            left_next   = cnt;
            ra_next     = '0;
            state_next  = S_SCAN;
          end
          default: begin
          end
        endcase
      end

      // One read issued per cycle; the word read last cycle is used now.
      S_SCAN: begin
        if (left != '0) begin
          mem_re     = 1'b1;
          pend_next  = 1'b1;
          paddr_next = ra;
          ra_next    = (op == OP_INSERT) ? ra - AW'(1) : ra + AW'(1);
          left_next  = left - CW'(1);
        end else begin
          pend_next = 1'b0;
        end

        if (pend) begin
          case (op)
            OP_INSERT: begin
              mem_we    = 1'b1;
              mem_waddr = paddr + AW'(1);
            end
            OP_DELETE: begin
              if (paddr == pos_m1_x[AW-1:0]) begin
                elem_next = mem_rdata;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = paddr - AW'(1);
              end
            end
            OP_GET: begin
              elem_next = mem_rdata;
            end
            OP_LOCATE: begin
              if (!hit && mem_rdata == val) begin
                hit_next    = 1'b1;
                status_next = STAT_OK;
                found_next  = found_x[POSW-1:0];
                left_next   = '0;
              end
            end
            default: begin
            end
          endcase
        end

        if (left == '0 && !pend) begin
          state_next = S_FINISH;
        end
      end

      // Commit the request and pass the response on once the output is free.
      S_FINISH: begin
        if (out_free) begin
          out_load   = 1'b1;
          cnt_next   = cnt_after;
          state_next = S_IDLE;
          if (op == OP_INSERT && status == STAT_OK) begin
            mem_we    = 1'b1;
            mem_waddr = pos_m1_x[AW-1:0];
            mem_wdata = val;
          end
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

endmodule

>>> sim/positional_array_list_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_array_list_unit_test: self-checking bench for the list unit
// Sends insert, delete, get, locate, clear and spare-opcode requests, keeps
// a private copy of the list to predict every response word, and compares
// the responses field by field in order. It runs a directed opening, then
// fill and drain tides of random requests under several idle patterns.
// ----------------------------------------------------------------------------
module positional_array_list_unit_test;
  import pal_pkg::*;

  // Opcodes the block does not define; they must leave the list untouched.
  localparam logic [OPW-1:0] OP_SPARE5 = 3'd5;
  localparam logic [OPW-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OPW-1:0] OP_SPARE7 = 3'd7;

  localparam int RANDOM_PER_PHASE = 425;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES     = 80;

  // Predicts responses from a private copy of the list and checks them.
  class list_scoreboard;
    logic [DATAW-1:0] store [PAL_DEPTH];
    int unsigned      count;
    pal_result_t      expected_q [$];
    int unsigned      mismatches;

    function new();
      count      = 0;
      mismatches = 0;
    endfunction

    function void report(string msg);
      mismatches++;
      if (mismatches <= 10) begin
        $display("%0t: %s", $time, msg);
      end
    endfunction

    // Applies one accepted request to the list copy and queues its response.
    function void note_request(logic [OPW-1:0] op, logic [POSW-1:0] pos,
                               logic [DATAW-1:0] val);
      pal_result_t r;
      int unsigned n;
      int          j;
      int unsigned found;
      r       = '0;
      r.status = STAT_OK;
      n       = count;
      found   = 0;
      case (op)
        OP_INSERT: begin
          if (pos < 1 || pos > n + 1) begin
            r.status = STAT_BADPOS;
          end else if (n >= PAL_DEPTH) begin
            r.status = STAT_FULL;
          end else begin
            for (j = n; j >= pos; j--) begin
              store[j] = store[j-1];
            end
            store[pos-1] = val;
            count = n + 1;
          end
        end
        OP_DELETE, OP_GET: begin
          if (n == 0) begin
            r.status = STAT_EMPTY;
          end else if (pos < 1 || pos > n) begin
            r.status = STAT_BADPOS;
          end else begin
            r.element = store[pos-1];
            if (op == OP_DELETE) begin
              for (j = pos; j < n; j++) begin
                store[j-1] = store[j];
              end
              count = n - 1;
            end
          end
        end
        OP_LOCATE: begin
          r.status = STAT_NOTFOUND;
          for (j = 0; j < n; j++) begin
            if (store[j] == val) begin
              found    = j + 1;
              r.status = STAT_OK;
              break;
            end
          end
        end
        OP_CLEAR: begin
          count = 0;
        end
        default: begin
        end
      endcase
      r.found_position = found[POSW-1:0];
      r.count          = CNTOW'(count);
      r.is_empty       = (count == 0);
      expected_q.push_back(r);
    endfunction

    // Compares one response word with the oldest expectation.
    function void check_result(pal_result_t act);
      pal_result_t exp;
      if (expected_q.size() == 0) begin
        report($sformatf("unexpected response: status %0d element %0d pos %0d %s",
                         act.status, act.element, act.found_position,
                         $sformatf("count %0d empty %0d", act.count, act.is_empty)));
        return;
      end
      exp = expected_q.pop_front();
      if (act.status !== exp.status || act.element !== exp.element ||
          act.found_position !== exp.found_position || act.count !== exp.count ||
          act.is_empty !== exp.is_empty) begin
        report({$sformatf("mismatch: expected status %0d element %0d pos %0d",
                          exp.status, exp.element, exp.found_position),
                $sformatf(" count %0d empty %0d, got status %0d element %0d",
                          exp.count, exp.is_empty, act.status, act.element),
                $sformatf(" pos %0d count %0d empty %0d",
                          act.found_position, act.count, act.is_empty)});
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;

  pal_req_if req ();
  pal_rsp_if rsp ();

  positional_array_list_unit dut (
    .clk(clk),
    .rst(rst),
    .req(req),
    .rsp(rsp)
  );

  list_scoreboard sb = new();

  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int hold_left    = 0;
  bit filling      = 1'b1;

  // Free-running 100 MHz clock.
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // Response ready: a long hold when asked, otherwise random stalls.
  always @(negedge clk) begin
    if (hold_left > 0) begin
      rsp.ready = 1'b0;
      hold_left = hold_left - 1;
    end else begin
      rsp.ready = ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  // Check every response word that is taken.
  always @(posedge clk) begin
    pal_result_t act;
    if (!rst && rsp.valid && rsp.ready) begin
      act.status         = pal_status_t'(rsp.status);
      act.element        = rsp.element;
      act.found_position = rsp.found_position;
      act.count          = rsp.count;
      act.is_empty       = rsp.is_empty;
      sb.check_result(act);
    end
  end

  // Hard stop in case the block hangs.
  initial begin
    #10_000_000;
    $display("Test completed with failures");
    $finish;
  end

  // Offers one request word and returns at the falling edge after it is taken.
  task automatic send_word(logic [OPW-1:0] op, logic [POSW-1:0] pos,
                           logic [DATAW-1:0] val);
    bit taken;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      req.valid    = 1'b0;
      req.opcode   = OPW'($urandom);
      req.position = POSW'($urandom);
      req.value    = DATAW'($urandom);
      @(negedge clk);
    end
    req.valid    = 1'b1;
    req.opcode   = op;
    req.position = pos;
    req.value    = val;
    do begin
      @(posedge clk);
      taken = req.ready;
      if (taken) begin
        sb.note_request(op, pos, val);
      end
      @(negedge clk);
    end while (!taken);
    req.valid = 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.expected_q.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Data values with extremes and a small pool so locate meets duplicates.
  function automatic logic [DATAW-1:0] pick_value();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return 32'h0000_0000;
      3: return 32'hffff_ffff;
      4, 5: return $urandom_range(0, 7);
      default: return $urandom;
    endcase
  endfunction

  // Builds one random request, mostly well-formed, following fill and drain
  // tides so the list reaches both full and empty.
  task automatic random_request();
    logic [OPW-1:0]   op;
    logic [POSW-1:0]  pos;
    logic [DATAW-1:0] val;
    int unsigned n;
    int          roll;
    n = sb.count;
    if (filling && n == PAL_DEPTH && $urandom_range(0, 3) == 0) begin
      filling = 1'b0;
    end else if (!filling && n == 0 && $urandom_range(0, 3) == 0) begin
      filling = 1'b1;
    end
    val  = pick_value();
    roll = $urandom_range(0, 99);
    if (roll < 8) begin
      // Noise: any opcode and any position.
      op  = OPW'($urandom_range(0, 7));
      pos = POSW'($urandom_range(0, 127));
    end else begin
      roll = $urandom_range(0, 99);
      if (filling) begin
        op = (roll < 60) ? OP_INSERT : (roll < 70) ? OP_DELETE :
             (roll < 83) ? OP_GET : (roll < 99) ? OP_LOCATE : OP_CLEAR;
      end else begin
        op = (roll < 10) ? OP_INSERT : (roll < 70) ? OP_DELETE :
             (roll < 83) ? OP_GET : (roll < 98) ? OP_LOCATE : OP_CLEAR;
      end
      case (op)
        OP_INSERT: begin
          pos = POSW'($urandom_range(1, n + 1));
        end
        OP_DELETE, OP_GET: begin
          pos = (n > 0) ? POSW'($urandom_range(1, n)) : 7'd1;
        end
        default: begin
          pos = POSW'($urandom_range(0, 127));
        end
      endcase
      if (op == OP_LOCATE && n > 0 && $urandom_range(0, 9) < 7) begin
        val = sb.store[$urandom_range(0, n - 1)];
      end
    end
    send_word(op, pos, val);
  endtask

  task automatic directed_requests();
    // Empty list: delete, get and locate have nothing to work on.
    send_word(OP_GET, 7'd1, 32'd0);
    send_word(OP_DELETE, 7'd1, 32'd0);
    send_word(OP_LOCATE, 7'd0, 32'd0);
    // Insert positions outside one to count plus one.
    send_word(OP_INSERT, 7'd0, 32'd5);
    send_word(OP_INSERT, 7'd2, 32'd5);
    send_word(OP_INSERT, 7'd127, 32'd5);
    // Build a short list with the value extremes.
    send_word(OP_INSERT, 7'd1, 32'h8000_0000);
    send_word(OP_INSERT, 7'd2, 32'h7fff_ffff);
    send_word(OP_INSERT, 7'd1, 32'hffff_ffff);
    send_word(OP_INSERT, 7'd2, 32'h7fff_ffff);
    send_word(OP_GET, 7'd4, 32'd0);
    send_word(OP_GET, 7'd5, 32'd0);
    send_word(OP_GET, 7'd0, 32'd0);
    send_word(OP_DELETE, 7'd0, 32'd0);
    send_word(OP_DELETE, 7'd127, 32'd0);
    // Locate returns the first of two equal elements, then a miss.
    send_word(OP_LOCATE, 7'd0, 32'h7fff_ffff);
    send_word(OP_LOCATE, 7'd127, 32'd12345);
    // Spare opcodes report the current count and change nothing.
    send_word(OP_SPARE5, 7'd1, 32'd1);
    send_word(OP_SPARE6, 7'd127, 32'hffff_ffff);
    send_word(OP_SPARE7, 7'd0, 32'd0);
    send_word(OP_DELETE, 7'd2, 32'd0);
    send_word(OP_DELETE, 7'd3, 32'd0);
    send_word(OP_CLEAR, 7'd0, 32'd0);
    send_word(OP_GET, 7'd1, 32'd0);
    send_word(OP_LOCATE, 7'd1, 32'h8000_0000);
  endtask

  initial begin
    req.valid    = 1'b0;
    req.opcode   = '0;
    req.position = '0;
    req.value    = '0;
    rsp.ready    = 1'b0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    directed_requests();
    wait_drained();

    // Idle patterns: none, sender idle, receiver stalling, both.
    for (int phase = 0; phase < 4; phase++) begin
      @(posedge clk);
      tx_idle_pct  = (phase == 1) ? 78 : (phase == 3) ? 18 : 0;
      rx_stall_pct = (phase == 2) ? 78 : (phase == 3) ? 18 : 0;
      @(negedge clk);
      for (int i = 0; i < RANDOM_PER_PHASE; i++) begin
        if (phase == 0 && i == 60) begin
          // Hold the response side off while requests keep coming.
          @(posedge clk);
          hold_left = LONG_HOLD_CYCLES;
          @(negedge clk);
        end
        random_request();
      end
      // Pause the sender until every response is back.
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(negedge clk);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      if (sb.expected_q.size() != 0) begin
        $display("%0d responses never arrived", sb.expected_q.size());
      end
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
